// ===== hdl/bgtl_pkg.sv =====
// ----------------------------------------------------------------------------
// bgtl_pkg
// Shared types, constants and helpers for the blue/gold teach/learn controller.
// ----------------------------------------------------------------------------
package bgtl_pkg;

  localparam int ENTRIES     = 8;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int SEL_W       = 4;
  localparam int EVENT_W     = 64;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_LEARN  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_LEARN = 2'd1,
    MODE_TEACH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_TEACH  = 2'd2
  } kind_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

  typedef struct packed {
    logic               opcode;
    logic               blue_pressed;
    logic               gold_pressed;
    logic [EVENT_W-1:0] evt_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IDX_W-1:0]   entry_index;
    logic [EVENT_W-1:0] event_id_out;
    logic [1:0]         mode;
    logic [SEL_W-1:0]   selection;
    logic               last;
  } out_item_t;

  // Work handed from the front to the back for one item.
  typedef struct packed {
    logic               teach_req;
    logic [IDX_W-1:0]   teach_idx;
    logic [ENTRIES-1:0] write_mask;
    logic [EVENT_W-1:0] evt_id;
    logic [1:0]         mode;
    logic [SEL_W-1:0]   selection;
  } cmd_t;

  function automatic logic [IDX_W-1:0] lowest_set(input logic [ENTRIES-1:0] m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/blue_gold_teach_learn_controller.sv =====
// ----------------------------------------------------------------------------
// blue_gold_teach_learn_controller
// Two-button teach/learn controller with queue-style item ports.
// ----------------------------------------------------------------------------
// Items enter through push/full and results leave through empty/pop. The
// front updates selection, gold mode and learn flags in the cycle an item is
// taken, so it takes one item per cycle while the command queue has room.
// The back turns each command into its results through a single output
// register, one per cycle while that register is free or being popped: a
// teach request if any, one write per flagged entry in ascending entry
// order, then a status item marked last. The back reads the next command
// only after it has loaded the status item of the last one; that sequencer
// and its output register set the rate.
// Mode and selection on every result are the values after the whole item.
// No memory clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module blue_gold_teach_learn_controller #(
  parameter int QUEUE_DEPTH = bgtl_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  bgtl_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output bgtl_pkg::out_item_t out_item
);

  bgtl_pkg::cmd_t cmd_in;   // command built by the front
  bgtl_pkg::cmd_t cmd_out;  // head of the queue
  logic           take;     // item accepted this cycle
  logic           q_empty;
  logic           q_rd;

  assign take = push && !full;

  bgtl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_item (in_item),
    .cmd     (cmd_in)
  );

  bgtl_cmdq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr      (take),
    .wr_data (cmd_in),
    .rd      (q_rd),
    .rd_data (cmd_out),
    .q_full  (full),
    .q_empty (q_empty)
  );

  bgtl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (cmd_out),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

// ===== hdl/bgtl_front.sv =====
// ----------------------------------------------------------------------------
// bgtl_front
// Takes items, updates selection, mode and learn flags, and issues a command.
// ----------------------------------------------------------------------------
module bgtl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  bgtl_pkg::in_item_t in_item,
  output bgtl_pkg::cmd_t     cmd
);

  logic [bgtl_pkg::SEL_W-1:0]   blue_count, blue_count_next;
  logic [1:0]                   gold_mode, gold_mode_next;
  logic [bgtl_pkg::ENTRIES-1:0] learn_flags, learn_flags_next;

  logic [bgtl_pkg::SEL_W:0]     blue_sum;
  logic [bgtl_pkg::SEL_W-1:0]   b1;
  logic [1:0]                   m1;
  logic [bgtl_pkg::IDX_W-1:0]   sel_idx0, sel_idx1;

  assign sel_idx0 = bgtl_pkg::IDX_W'(blue_count - 1'b1);
  assign sel_idx1 = bgtl_pkg::IDX_W'(b1 - 1'b1);
  assign blue_sum = {1'b0, blue_count} + 1'b1;

  // blue stage
  always_comb begin
    b1 = blue_count;
    m1 = gold_mode;
    if (in_item.blue_pressed) begin
      b1 = (blue_sum > (bgtl_pkg::SEL_W + 1)'(bgtl_pkg::ENTRIES)) ? '0
           : blue_sum[bgtl_pkg::SEL_W-1:0];
      if (gold_mode == bgtl_pkg::MODE_OFF) begin
        m1 = bgtl_pkg::MODE_LEARN;
      end
    end
  end

  // gold stage and learn event
  always_comb begin
    blue_count_next  = blue_count;
    gold_mode_next   = gold_mode;
    learn_flags_next = learn_flags;
    cmd              = '0;
    cmd.evt_id       = in_item.evt_id;
    if (in_item.opcode == bgtl_pkg::OP_UPDATE) begin
      blue_count_next = b1;
      gold_mode_next  = m1;
      if (in_item.gold_pressed) begin
        unique case (m1)
          bgtl_pkg::MODE_OFF: begin
            gold_mode_next  = bgtl_pkg::MODE_TEACH;
            blue_count_next = bgtl_pkg::SEL_W'(1);
          end
          bgtl_pkg::MODE_LEARN: begin
            if (b1 != '0) begin
              learn_flags_next[sel_idx1] = 1'b1;
              blue_count_next            = bgtl_pkg::SEL_W'(1);
            end
          end
          default: begin
            cmd.teach_req   = (b1 != '0);
            cmd.teach_idx   = sel_idx1;
            gold_mode_next  = bgtl_pkg::MODE_OFF;
            blue_count_next = '0;
          end
        endcase
      end
    end else begin
      cmd.write_mask = learn_flags;
      if (blue_count != '0) begin
        cmd.write_mask[sel_idx0] = 1'b1;
      end
      learn_flags_next = '0;
      gold_mode_next   = bgtl_pkg::MODE_OFF;
      blue_count_next  = '0;
    end
    cmd.mode      = gold_mode_next;
    cmd.selection = blue_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blue_count  <= '0;
      gold_mode   <= bgtl_pkg::MODE_OFF;
      learn_flags <= '0;
    end else if (take) begin
      blue_count  <= blue_count_next;
      gold_mode   <= gold_mode_next;
      learn_flags <= learn_flags_next;
    end
  end

endmodule

// ===== hdl/bgtl_cmdq.sv =====
// ----------------------------------------------------------------------------
// bgtl_cmdq
// Small command queue between front and back.
// ----------------------------------------------------------------------------
module bgtl_cmdq #(
  parameter int DEPTH = bgtl_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  bgtl_pkg::cmd_t wr_data,
  input  logic           rd,
  output bgtl_pkg::cmd_t rd_data,
  output logic           q_full,
  output logic           q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bgtl_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/bgtl_back.sv =====
// ----------------------------------------------------------------------------
// bgtl_back
// Expands one command into teach/write results and a closing status item.
// ----------------------------------------------------------------------------
module bgtl_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  bgtl_pkg::cmd_t      q_data,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output bgtl_pkg::out_item_t out_item
);

  bgtl_pkg::back_state_t state, state_next;
  bgtl_pkg::cmd_t        cur, cur_next;
  bgtl_pkg::out_item_t   res;
  logic                  out_valid;
  logic                  out_free;
  logic                  load;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bgtl_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (load) begin
      out_item <= res;
    end
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    q_rd            = 1'b0;
    load            = 1'b0;
    res             = '0;
    res.mode        = cur.mode;
    res.selection   = cur.selection;
    res.kind        = bgtl_pkg::KIND_STATUS;
    unique case (state)
      bgtl_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_rd       = 1'b1;
          cur_next   = q_data;
          state_next = bgtl_pkg::BK_RUN;
        end
      end
      bgtl_pkg::BK_RUN: begin
        if (out_free) begin
          load = 1'b1;
          if (cur.teach_req) begin
            res.kind           = bgtl_pkg::KIND_TEACH;
            res.entry_index    = cur.teach_idx;
            cur_next.teach_req = 1'b0;
          end else if (cur.write_mask != '0) begin
            res.kind            = bgtl_pkg::KIND_WRITE;
            res.entry_index     = bgtl_pkg::lowest_set(cur.write_mask);
            res.event_id_out    = cur.evt_id;
            cur_next.write_mask = cur.write_mask & (cur.write_mask - 1'b1);
          end else begin
            res.last   = 1'b1;
            state_next = bgtl_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_next = bgtl_pkg::BK_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/bgtl_checker.sv =====
// ----------------------------------------------------------------------------
// bgtl_checker
// Port-level checks for the teach/learn controller, bound to the top level.
// ----------------------------------------------------------------------------
module bgtl_checker (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input bgtl_pkg::out_item_t out_item
);

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("not idle after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result changed while waiting");

  // exactly the status item closes each input item
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_item.last == (out_item.kind == bgtl_pkg::KIND_STATUS)))
    else $error("last flag does not match status kind");

  // teach and write both end the item in mode off with no selection
  a_action_off: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.kind != bgtl_pkg::KIND_STATUS) |->
      (out_item.mode == bgtl_pkg::MODE_OFF && out_item.selection == '0))
    else $error("action result not in mode off");

  // status carries no entry and no event id
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.kind == bgtl_pkg::KIND_STATUS) |->
      (out_item.entry_index == '0 && out_item.event_id_out == '0))
    else $error("status item carries payload");

endmodule

bind blue_gold_teach_learn_controller bgtl_checker u_bgtl_checker (.*);
